FILE: hw/rtl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared constants, types and tables for the polar-to-Cartesian scan block.
// ----------------------------------------------------------------------------
package p2c_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int SAMPLE_BITS       = 16;

  localparam int ITER_W  = 5;
  localparam int D4_W    = 30;
  localparam int R_W     = 21;
  localparam int ANGLE_W = 22;

  localparam logic [22:0] FULL_TURN    = 23'd3600000;
  localparam logic [22:0] TWO_TURNS    = 23'd7200000;
  localparam logic [22:0] HALF_TURN    = 23'd1800000;
  localparam logic [22:0] QUARTER_TURN = 23'd900000;
  localparam logic [22:0] THREE_QUART  = 23'd2700000;

  // z = r * (pi * 2^30) / 1800000, reduced to r * 1686629713 / 900000
  localparam logic [30:0] Z_NUM = 31'd1686629713;
  localparam logic [19:0] Z_DEN = 20'd900000;
  // floor(Z_NUM * 2^20 / Z_DEN); the quotient estimate it gives is low by at
  // most one for any reduced angle.
  localparam logic [30:0] Z_RECIP = 31'd1965066042;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;
  localparam logic [1:0] REG_STEP   = 2'd3;

  typedef struct packed {
    logic signed [D4_W-1:0] d4;
    logic signed [R_W-1:0]  r;
    logic                   flip;
    logic                   last;
  } p2c_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } p2c_qstat_t;

  function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/p2c_front.sv
// ----------------------------------------------------------------------------
// p2c_front
// Holds configuration and the beam angle, turns each sample into a distance
// and a reduced angle, and pushes the result into the work queue.
// ----------------------------------------------------------------------------
module p2c_front
  import p2c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic              smp_take,
  input  logic [15:0]       smp_raw,
  input  logic              smp_last,
  output p2c_item_t         item
);

  logic [23:0]        scale_r, scale_nxt;
  logic signed [31:0] offset_r, offset_nxt;
  logic [ANGLE_W-1:0] start_r, start_nxt;
  logic [21:0]        step_r, step_nxt;
  logic [ANGLE_W-1:0] beam_r, beam_nxt;

  logic signed [23:0] s_ext;
  logic signed [23:0] s_wrap;
  logic [22:0]        sum;
  logic [22:0]        sum_wrap;
  logic [15:0]        raw;
  logic [39:0]        prod;
  logic signed [41:0] d16;
  logic [22:0]        a;

  // Reduce a newly written start angle into one turn.
  always_comb begin
    s_ext = 24'(signed'(cfg_wdata[22:0]));
    if (s_ext < -24'sd3600000) begin
      s_wrap = s_ext + 24'sd7200000;
    end else if (s_ext < 24'sd0) begin
      s_wrap = s_ext + 24'sd3600000;
    end else if (s_ext >= 24'sd3600000) begin
      s_wrap = s_ext - 24'sd3600000;
    end else begin
      s_wrap = s_ext;
    end
  end

  always_comb begin
    sum = 23'(beam_r) + 23'(step_r);
    if (sum >= TWO_TURNS) begin
      sum_wrap = sum - TWO_TURNS;
    end else if (sum >= FULL_TURN) begin
      sum_wrap = sum - FULL_TURN;
    end else begin
      sum_wrap = sum;
    end
  end

  always_comb begin
    scale_nxt  = scale_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    step_nxt   = step_r;
    beam_nxt   = beam_r;
    if (smp_take) begin
      beam_nxt = smp_last ? start_r : sum_wrap[ANGLE_W-1:0];
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:  scale_nxt  = cfg_wdata[23:0];
        REG_OFFSET: offset_nxt = signed'(cfg_wdata);
        REG_START: begin
          start_nxt = s_wrap[ANGLE_W-1:0];
          beam_nxt  = s_wrap[ANGLE_W-1:0];
        end
        REG_STEP:   step_nxt   = cfg_wdata[21:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 24'd65536;
      offset_r <= 32'sd0;
      start_r  <= 22'd3150000;
      step_r   <= 22'd10000;
      beam_r   <= 22'd3150000;
    end else begin
      scale_r  <= scale_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      step_r   <= step_nxt;
      beam_r   <= beam_nxt;
    end
  end

  // Distance in Q4 mm, rounded half up. No clamp is needed: the result always fits this width.
  always_comb begin
    raw  = smp_raw & 16'((33'd1 << SAMPLE_BITS) - 33'd1);
    prod = 40'(raw) * 40'(scale_r);
    d16  = signed'({2'b00, prod}) + 42'(offset_r) + 42'sd2048;
  end

  // Fold the angle into the half turn around zero; the far half flips sign.
  always_comb begin
    item.d4 = d16[D4_W+11:12];
    a = 23'(beam_r);
    item.flip = 1'b0;
    if (a < QUARTER_TURN) begin
      item.r = signed'(R_W'(a));
    end else if (a < THREE_QUART) begin
      item.r    = signed'(R_W'(a - HALF_TURN));
      item.flip = 1'b1;
    end else begin
      item.r = signed'(R_W'(a - FULL_TURN));
    end
    item.last = smp_last;
  end

endmodule

FILE: hw/rtl/p2c_queue.sv
// ----------------------------------------------------------------------------
// p2c_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module p2c_queue
  import p2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  p2c_item_t  push_item,
  input  logic       pop,
  output p2c_item_t  pop_item,
  output p2c_qstat_t stat
);

  p2c_item_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  assign pop_item   = mem_r[rptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

endmodule

FILE: hw/rtl/p2c_back.sv
// ----------------------------------------------------------------------------
// p2c_back
// Sequencer that converts the angle to Q30 radians by reciprocal
// multiplication, runs the CORDIC rotation, scales by distance and drives
// the output register.
// ----------------------------------------------------------------------------
module p2c_back
  import p2c_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  p2c_qstat_t   qstat,
  input  p2c_item_t    qitem,
  output logic         qpop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,
  output logic         out_tlast
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_ROT  = 4'd3;
  localparam logic [3:0] S_MXL  = 4'd4;
  localparam logic [3:0] S_MXH  = 4'd5;
  localparam logic [3:0] S_MYL  = 4'd6;
  localparam logic [3:0] S_MYH  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_FIX  = 4'd9;

  logic [3:0]               state_r, state_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic                     ovalid_r, ovalid_nxt;

  logic signed [D4_W-1:0]   d4_r, d4_nxt;
  logic                     flip_r, flip_nxt;
  logic                     last_r, last_nxt;
  logic                     neg_r, neg_nxt;
  logic [19:0]              mag_r, mag_nxt;
  logic [20:0]              rem_r, rem_nxt;
  logic [30:0]              quo_r, quo_nxt;
  logic signed [32:0]       z_r, z_nxt;
  logic signed [32:0]       cx_r, cx_nxt;
  logic signed [32:0]       cy_r, cy_nxt;
  logic signed [63:0]       acc_r, acc_nxt;
  logic signed [31:0]       xres_r, xres_nxt;
  logic signed [31:0]       yres_r, yres_nxt;
  logic [63:0]              odata_r, odata_nxt;
  logic                     olast_r, olast_nxt;

  logic [50:0]              est;
  logic [20:0]              num_lo;
  logic [20:0]              qden_lo;
  logic signed [32:0]       dx, dy, at;
  logic signed [32:0]       mop;
  logic signed [16:0]       mpart;
  logic signed [46:0]       prod;
  logic signed [33:0]       rnd;
  logic signed [31:0]       sat;
  logic                     out_free;

  assign out_free = !ovalid_r || out_tready;

  always_comb begin
    // The remainder of the estimate is below two divisors, so its low
    // 21 bits are exact.
    est     = 51'(mag_r) * 51'(Z_RECIP);
    num_lo  = 21'(mag_r) * 21'(Z_NUM);
    qden_lo = quo_r[20:0] * 21'(Z_DEN);
    dx    = cy_r >>> cnt_r;
    dy    = cx_r >>> cnt_r;
    at    = 33'(atan_q30(cnt_r));
    // Sine carries x, negated cosine carries y; the fold flips both.
    if (state_r == S_MXL || state_r == S_MXH) begin
      mop = flip_r ? -cy_r : cy_r;
    end else begin
      mop = flip_r ? cx_r : -cx_r;
    end
    if (state_r == S_MXL || state_r == S_MYL) begin
      mpart = signed'({1'b0, mop[15:0]});
    end else begin
      mpart = mop[32:16];
    end
    prod = 47'(d4_r) * 47'(mpart);
    if (state_r == S_MXL || state_r == S_MYL) begin
      acc_nxt = 64'(prod);
    end else begin
      acc_nxt = acc_r + (64'(prod) <<< 16);
    end
    rnd = 34'((acc_nxt + 64'sd536870912) >>> 30);
    if (rnd > 34'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (rnd < -34'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = rnd[31:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_tready;
    d4_nxt     = d4_r;
    flip_nxt   = flip_r;
    last_nxt   = last_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    z_nxt      = z_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    xres_nxt   = xres_r;
    yres_nxt   = yres_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    qpop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!qstat.empty) begin
          qpop      = 1'b1;
          d4_nxt    = qitem.d4;
          flip_nxt  = qitem.flip;
          last_nxt  = qitem.last;
          neg_nxt   = qitem.r[R_W-1];
          mag_nxt   = qitem.r[R_W-1] ? 20'(-qitem.r) : 20'(qitem.r);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        quo_nxt   = est[50:20];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt   = num_lo - qden_lo;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        if (rem_r >= 21'(Z_DEN)) begin
          quo_nxt = quo_r + 31'd1;
        end
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        if (cnt_r == '0) begin
          // First rotation starts from the gain on the x axis.
          z_nxt = neg_r ? -33'(quo_r) : 33'(quo_r);
          if (!neg_r) begin
            cx_nxt = GAIN_Q30;
            cy_nxt = GAIN_Q30;
            z_nxt  = 33'(quo_r) - at;
          end else begin
            cx_nxt = GAIN_Q30;
            cy_nxt = -GAIN_Q30;
            z_nxt  = -33'(quo_r) + at;
          end
        end else if (z_r >= 0) begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          z_nxt  = z_r - at;
        end else begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          z_nxt  = z_r + at;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITER_W'(CORDIC_ITERATIONS - 1)) begin
          state_nxt = S_MXL;
        end
      end
      S_MXL: state_nxt = S_MXH;
      S_MXH: begin
        xres_nxt  = sat;
        state_nxt = S_MYL;
      end
      S_MYL: state_nxt = S_MYH;
      S_MYH: begin
        yres_nxt  = sat;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          odata_nxt  = {yres_r, xres_r};
          olast_nxt  = last_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d4_r    <= d4_nxt;
    flip_r  <= flip_nxt;
    last_r  <= last_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    z_r     <= z_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    acc_r   <= acc_nxt;
    xres_r  <= xres_nxt;
    yres_r  <= yres_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

FILE: hw/rtl/polar_to_cartesian_scan.sv
// ----------------------------------------------------------------------------
// polar_to_cartesian_scan
// Converts a stream of lidar range samples into Cartesian points.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[15:0] distance_raw, tlast last_of_scan
//   out_     master     tdata[31:0] x_mm_q4, tdata[63:32] y_mm_q4,
//                       tlast last_out
//   cfg_     write      index 0 scale, 1 offset, 2 start angle, 3 step
//
// In the back sequencer each point passes the angle conversion (S_MUL, S_DIV,
// S_FIX), the CORDIC loop and the distance products (S_MXL to S_MYH).
// The front takes a sample whenever the two-entry queue has room.
// A finished point waits in the output register; the back goes on with the
// next sample and stalls only when a new point is ready before it is taken.
// Reset is synchronous and active low; it needs no clearing pass.
// ----------------------------------------------------------------------------
module polar_to_cartesian_scan
  import p2c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] distance_raw
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] x_mm_q4, [63:32] y_mm_q4
  output logic        out_tlast
);

  p2c_item_t  f_item;
  p2c_item_t  q_item;
  p2c_qstat_t q_stat;
  logic       take;
  logic       pop;

  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;

  p2c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .smp_take  (take),
    .smp_raw   (in_tdata),
    .smp_last  (in_tlast),
    .item      (f_item)
  );

  p2c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_item (f_item),
    .pop       (pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  p2c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (q_stat),
    .qitem      (q_item),
    .qpop       (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: verif/tb_polar_to_cartesian_scan.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polar_to_cartesian_scan
// Streams range samples through the scan converter under several register
// settings and compares every point, field by field, against a bit-exact
// predictor of the angle accumulator, the CORDIC and the scaling.
// ----------------------------------------------------------------------------
module tb_polar_to_cartesian_scan;
  import p2c_pkg::*;

  localparam int  LIMIT_CYCLES = 2000000;
  localparam int  DRAIN_CYCLES = 120;
  localparam longint TURN = 3600000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
  } point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_SCALE;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] distance_raw
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [31:0] x_mm_q4, [63:32] y_mm_q4
  logic        out_tlast;

  // Predictor copy of the registers and the beam angle.
  longint unsigned scale_q16;
  longint          offset_q16;
  longint          start_angle;
  longint          angle_step;
  longint          beam_angle;

  point_t pending_points[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  int     burst_left = 0;
  int     stall_mode = 0;
  bit     no_gaps = 1'b0;

  polar_to_cartesian_scan uut (.*);

  always #6 clk = ~clk;

  function automatic longint wrap_turn(longint v);
    longint m;
    m = v % TURN;
    if (m < 0) m += TURN;
    return m;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[16] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767};
    return tbl[i];
  endfunction

  // Computes the point for one sample at the current beam angle and
  // advances the angle, or reloads the start angle after the last sample.
  function automatic point_t predict_point(logic [15:0] raw, logic last);
    point_t p;
    longint d16, d4, r, z, cx, cy, dx, dy;
    bit     flip;
    d16 = longint'(raw) * longint'(scale_q16) + offset_q16;
    d4 = (d16 + 2048) >>> 12;
    if (d4 > 64'sd4294967295) d4 = 64'sd4294967295;
    if (d4 < -64'sd4294967295) d4 = -64'sd4294967295;
    flip = 1'b0;
    if (beam_angle < 900000) r = beam_angle;
    else if (beam_angle < 2700000) begin
      r = beam_angle - 1800000;
      flip = 1'b1;
    end else r = beam_angle - TURN;
    z = (r * 64'sd3373259426) / 64'sd1800000;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= atan_entry(i);
      end else begin
        cx += dx; cy -= dy; z += atan_entry(i);
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    p.x = 32'(sat32((d4 * cy + (64'sd1 << 29)) >>> 30));
    p.y = 32'(sat32((-(d4 * cx) + (64'sd1 << 29)) >>> 30));
    p.last = last;
    if (last) beam_angle = wrap_turn(start_angle);
    else beam_angle = wrap_turn(beam_angle + angle_step);
    return p;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stall pattern, drawn at random from four modes.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(1) == 1);
      2: out_tready <= ($urandom_range(5) == 0);
      default: out_tready <= ((cycle_count / 40) % 2 == 0);
    endcase
  end

  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]), out_tlast);
        fail_count++;
      end else begin
        e = pending_points.pop_front();
        if (out_tdata[31:0] !== e.x) begin
          $display("%0t: x expected %0d actual %0d", $time, e.x,
                   $signed(out_tdata[31:0]));
          fail_count++;
        end
        if (out_tdata[63:32] !== e.y) begin
          $display("%0t: y expected %0d actual %0d", $time, e.y,
                   $signed(out_tdata[63:32]));
          fail_count++;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Sends one sample; samples go in bursts, with random gaps unless no_gaps is set.
  task automatic send_sample(logic [15:0] raw, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!no_gaps && $urandom_range(3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tlast  <= last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    pending_points.push_back(predict_point(raw, last));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The write enable is lowered again after each write, before the predictor copy is updated.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SCALE:  scale_q16 = value[23:0];
      REG_OFFSET: offset_q16 = longint'($signed(value));
      REG_START: begin
        start_angle = longint'($signed(value[22:0]));
        beam_angle  = wrap_turn(start_angle);
      end
      REG_STEP:   angle_step = value[21:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [23:0] sc, logic [31:0] off, longint st, logic [21:0] step);
    write_reg(REG_SCALE, {8'h0, sc});
    write_reg(REG_OFFSET, off);
    write_reg(REG_STEP, {10'h0, step});
    write_reg(REG_START, 32'(st));
  endtask

  // Reset values, raw extremes, end-of-scan reload and quadrant edges.
  task automatic test_directed();
    no_gaps = 1'b1;
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h1234, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    wait_idle();
    set_all(24'hFFFFFF, 32'h7FFFFFFF, 900000, 22'd1800000);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    wait_idle();
    // A negative offset larger than the scaled sample mirrors the point.
    set_all(24'd65536, 32'h80000000, -3600000, 22'd3600000);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
    set_all(24'd0, 32'd0, 3600000, 22'd0);
    send_sample(16'hFFFF, 1'b0);
    wait_idle();
    set_all(24'd100000, 32'd12345, 2700000, 22'd899999);
    no_gaps = 1'b0;
    for (int i = 0; i < 8; i++) send_sample(16'($urandom), 1'b0);
    // A start angle write in the middle of a scan reloads the angle.
    wait_idle();
    write_reg(REG_START, 32'(-1));
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    wait_idle();
  endtask

  // Random settings with whole scans of random samples.
  task automatic test_random_scans();
    int count;
    longint st;
    count = 0;
    while (count < 1300) begin
      st = longint'($urandom_range(7200000)) - 3600000;
      case ($urandom_range(3))
        0: set_all(24'($urandom), $urandom, st, 22'($urandom_range(3600000)));
        1: set_all(24'($urandom_range(65536, 200000)), $urandom_range(4000000),
                   st, 22'($urandom_range(40000)));
        2: set_all(24'($urandom), 32'(-$urandom_range(1 << 30)), st,
                   22'($urandom_range(3600000)));
        default: set_all(24'd65536, 32'd0, st, 22'($urandom_range(100)));
      endcase
      no_gaps = ($urandom_range(4) == 0);
      repeat ($urandom_range(1, 4)) begin
        int len;
        len = $urandom_range(1, 60);
        for (int i = 0; i < len; i++) begin
          send_sample(16'($urandom), (i == len - 1) || ($urandom_range(50) == 0));
          count++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    scale_q16   = 65536;
    offset_q16  = 0;
    start_angle = -450000;
    angle_step  = 10000;
    beam_angle  = wrap_turn(start_angle);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_scans();
    wait_idle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
